// ----- design/esi_pkg.sv -----
package esi_pkg;

   localparam int VALUE_WIDTH_DEF    = 32;
   localparam int POS_FRAC_BITS_DEF  = 15;
   localparam int POSITION_WIDTH     = 16;
   localparam int EDGE_TYPE_WIDTH    = 2;
   localparam int NODE_COUNT         = 4;

   // register stages from the input beat to the registered weights
   localparam int WEIGHT_LATENCY     = 4;

   typedef enum logic [EDGE_TYPE_WIDTH-1:0] {
      EDGE_LINEAR    = 2'd0,
      EDGE_QUADRATIC = 2'd1,
      EDGE_CUBIC     = 2'd2
   } edge_kind_type;

endpackage

// ----- design/edge_shape_interpolation_unit.sv -----
// Lagrange interpolation along a linear, quadratic or cubic edge. A beat is
// taken on every cycle that start is high; busy never rises, so one point
// per cycle flows through. Each result leaves on rsp_strobe once its start
// beat has passed the four weight stages (clamp, factor products,
// numerators, rounding) and three accumulate stages (value products, sum,
// rescale and clip). The receiver cannot stall, so results appear
// unconditionally. Write edge_type only when no beat is in flight.
module edge_shape_interpolation_unit import esi_pkg::*; #(
   parameter int VALUE_WIDTH        = VALUE_WIDTH_DEF,
   parameter int POSITION_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [POSITION_WIDTH-1:0]     req_position,
   input  logic signed [VALUE_WIDTH-1:0] req_value_end_a,
   input  logic signed [VALUE_WIDTH-1:0] req_value_end_b,
   input  logic signed [VALUE_WIDTH-1:0] req_value_inner_one,
   input  logic signed [VALUE_WIDTH-1:0] req_value_inner_two,
   output logic                          rsp_strobe,
   output logic signed [VALUE_WIDTH-1:0] rsp_interpolated,
   output logic                          rsp_saturated_flag,
   input  logic                          csr_write_en,
   input  logic [EDGE_TYPE_WIDTH-1:0]    csr_write_data
);

   localparam int WW = POSITION_FRAC_BITS + 3;

   edge_kind_type                edge_type_ff;
   logic                         accept;
   logic signed [VALUE_WIDTH-1:0] val_in [NODE_COUNT];
   logic signed [VALUE_WIDTH-1:0] val_ff [WEIGHT_LATENCY][NODE_COUNT];
   logic                         weight_valid;
   logic signed [WW-1:0]         weight [NODE_COUNT];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_type_ff <= EDGE_LINEAR;
      end else if (csr_write_en) begin
         edge_type_ff <= edge_kind_type'(csr_write_data);
      end
   end

   assign val_in[0] = req_value_end_a;
   assign val_in[1] = req_value_end_b;
   assign val_in[2] = req_value_inner_one;
   assign val_in[3] = req_value_inner_two;

   // hold the nodal values alongside the weight stages
   always_ff @(posedge clock) begin
      val_ff[0] <= val_in;
      for (int k = 1; k < WEIGHT_LATENCY; k++) begin
         val_ff[k] <= val_ff[k-1];
      end
   end

   esi_weight #(
      .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
   ) u_weight (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .position     (req_position),
      .edge_type    (edge_type_ff),
      .weight_valid (weight_valid),
      .weight       (weight)
   );

   esi_mac #(
      .VALUE_WIDTH        (VALUE_WIDTH),
      .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (weight_valid),
      .value     (val_ff[WEIGHT_LATENCY-1]),
      .weight    (weight),
      .out_valid (rsp_strobe),
      .result    (rsp_interpolated),
      .saturated (rsp_saturated_flag)
   );

endmodule

// ----- design/esi_weight.sv -----
module esi_weight import esi_pkg::*; #(
   parameter int POSITION_FRAC_BITS = POS_FRAC_BITS_DEF,
   localparam int WW = POSITION_FRAC_BITS + 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [POSITION_WIDTH-1:0]  position,
   input  edge_kind_type              edge_type,
   output logic                       weight_valid,
   output logic signed [WW-1:0]       weight [NODE_COUNT]
);

   localparam int F  = POSITION_FRAC_BITS;
   localparam int P  = F + 1;
   localparam int CW = (P > POSITION_WIDTH) ? P : POSITION_WIDTH;
   localparam int FW = F + 6;
   localparam int NW = 3 * FW;

   // stage 1: clamped position
   logic [WEIGHT_LATENCY-1:0] vld_ff, vld_in;
   logic [P-1:0]              p_ff, p_in;
   edge_kind_type             type1_ff, type2_ff, type3_ff;

   // stage 2: first products and third factors
   logic signed [2*FW-1:0]    prod_ff [NODE_COUNT];
   logic signed [2*FW-1:0]    prod_in [NODE_COUNT];
   logic signed [FW-1:0]      third_ff [NODE_COUNT];
   logic signed [FW-1:0]      third_in [NODE_COUNT];
   logic signed [FW-1:0]      ps2_ff, ps3_ff;

   // stage 3: full numerators
   logic signed [NW-1:0]      num_ff [NODE_COUNT];
   logic signed [NW-1:0]      num_in [NODE_COUNT];

   // stage 4: weights
   logic signed [WW-1:0]      weight_ff [NODE_COUNT];
   logic signed [WW-1:0]      weight_in [NODE_COUNT];

   logic [CW-1:0]             pos_ext, one_ext;
   logic signed [FW-1:0]      ps, sf, s_m_p, s_m_2p, p3, p9;
   logic signed [FW-1:0]      fa [NODE_COUNT];
   logic signed [FW-1:0]      fb [NODE_COUNT];
   logic signed [NW-1:0]      qhalf, chalf;
   logic signed [NW-1:0]      rq, rc;
   logic signed [FW-1:0]      lin_a;

   assign vld_in = {vld_ff[WEIGHT_LATENCY-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: clamp anything above one to one
   always_comb begin
      pos_ext = CW'(position);
      one_ext = CW'(1) << F;
      if (pos_ext > one_ext) begin
         p_in = one_ext[P-1:0];
      end else begin
         p_in = pos_ext[P-1:0];
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      type1_ff <= edge_type;
   end

   // stage 2: factor pairs per node, multiplied
   always_comb begin
      ps     = signed'(FW'(p_ff));
      sf     = signed'(FW'(1) << F);
      s_m_p  = sf - ps;
      s_m_2p = sf - (ps <<< 1);
      p3     = ps + (ps <<< 1);
      p9     = (ps <<< 3) + ps;
      for (int i = 0; i < NODE_COUNT; i++) begin
         fa[i]       = '0;
         fb[i]       = '0;
         third_in[i] = '0;
      end
      unique case (type1_ff)
         EDGE_QUADRATIC: begin
            fa[0] = s_m_p;      fb[0] = s_m_2p;
            fa[1] = ps;         fb[1] = -s_m_2p;
            fa[2] = ps <<< 2;   fb[2] = s_m_p;
         end
         EDGE_CUBIC: begin
            fa[0] = s_m_p;      fb[0] = p3 - sf;
            fa[1] = ps;         fb[1] = p3 - sf;
            fa[2] = p9;         fb[2] = -s_m_p;
            fa[3] = p9;         fb[3] = s_m_p;
            third_in[0] = p3 - (sf <<< 1);
            third_in[1] = p3 - (sf <<< 1);
            third_in[2] = p3 - (sf <<< 1);
            third_in[3] = p3 - sf;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < NODE_COUNT; i++) begin
         prod_in[i] = fa[i] * fb[i];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      third_ff <= third_in;
      ps2_ff   <= ps;
      type2_ff <= type1_ff;
   end

   // stage 3: cubic takes the third factor, linear and quadratic pass through
   always_comb begin
      for (int i = 0; i < NODE_COUNT; i++) begin
         if (type2_ff == EDGE_CUBIC) begin
            num_in[i] = prod_ff[i] * third_ff[i];
         end else begin
            num_in[i] = {{(NW-2*FW){prod_ff[i][2*FW-1]}}, prod_ff[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      ps3_ff   <= ps2_ff;
      type3_ff <= type2_ff;
   end

   // stage 4: round half up to Q.F, select by edge type
   assign qhalf = signed'(NW'(1) << (F - 1));
   assign chalf = signed'(NW'(1) << (2 * F));
   assign lin_a = signed'(FW'(1) << F) - ps3_ff;

   always_comb begin
      rq = '0;
      rc = '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
         weight_in[i] = '0;
      end
      unique case (type3_ff)
         EDGE_LINEAR: begin
            weight_in[0] = lin_a[WW-1:0];
            weight_in[1] = ps3_ff[WW-1:0];
         end
         EDGE_QUADRATIC: begin
            for (int i = 0; i < NODE_COUNT - 1; i++) begin
               rq           = (num_ff[i] + qhalf) >>> F;
               weight_in[i] = rq[WW-1:0];
            end
         end
         EDGE_CUBIC: begin
            for (int i = 0; i < NODE_COUNT; i++) begin
               rc           = (num_ff[i] + chalf) >>> (2 * F + 1);
               weight_in[i] = rc[WW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
   end

   assign weight_valid = vld_ff[WEIGHT_LATENCY-1];
   assign weight       = weight_ff;

endmodule

// ----- design/esi_mac.sv -----
module esi_mac import esi_pkg::*; #(
   parameter int VALUE_WIDTH        = VALUE_WIDTH_DEF,
   parameter int POSITION_FRAC_BITS = POS_FRAC_BITS_DEF,
   localparam int WW = POSITION_FRAC_BITS + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [VALUE_WIDTH-1:0] value [NODE_COUNT],
   input  logic signed [WW-1:0]          weight [NODE_COUNT],
   output logic                          out_valid,
   output logic signed [VALUE_WIDTH-1:0] result,
   output logic                          saturated
);

   localparam int F  = POSITION_FRAC_BITS;
   localparam int VW = VALUE_WIDTH;
   localparam int MW = VW + WW;
   localparam int AW = MW + 2;

   logic [2:0]              vld_ff, vld_in;
   logic signed [MW-1:0]    prod_ff [NODE_COUNT];
   logic signed [MW-1:0]    prod_in [NODE_COUNT];
   logic signed [AW-1:0]    sum_ff, sum_in;
   logic signed [VW-1:0]    result_ff, result_in;
   logic                    sat_ff, sat_in;
   logic signed [AW-1:0]    rhalf, shifted;
   logic [AW-VW:0]          top_bits;

   assign vld_in = {vld_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NODE_COUNT; i++) begin
         prod_in[i] = value[i] * weight[i];
      end
   end

   // sum with the rounding half folded in
   assign rhalf  = signed'(AW'(1) << (F - 1));
   assign sum_in = AW'(prod_ff[0]) + AW'(prod_ff[1]) + AW'(prod_ff[2])
                 + AW'(prod_ff[3]) + rhalf;

   // drop the fraction, then clip to the value range
   always_comb begin
      shifted  = sum_ff >>> F;
      top_bits = shifted[AW-1:VW-1];
      if ((&top_bits) || !(|top_bits)) begin
         result_in = shifted[VW-1:0];
         sat_in    = 1'b0;
      end else begin
         sat_in = 1'b1;
         if (shifted[AW-1]) begin
            result_in = {1'b1, {(VW-1){1'b0}}};
         end else begin
            result_in = {1'b0, {(VW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      result_ff <= result_in;
      sat_ff    <= sat_in;
   end

   assign out_valid = vld_ff[2];
   assign result    = result_ff;
   assign saturated = sat_ff;

endmodule

// ----- tb/testbench.sv -----
module testbench;
   import esi_pkg::*;

   localparam int VW = VALUE_WIDTH_DEF;
   localparam int FRAC = POS_FRAC_BITS_DEF;
   localparam int UNIT_POS = 1 << FRAC;
   localparam logic [EDGE_TYPE_WIDTH-1:0] EDGE_UNUSED = 2'd3;
   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam int PIPE_DEPTH = WEIGHT_LATENCY + 3;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_POINTS = 231;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [VW-1:0] value;
      logic                 clipped;
   } interp_result_type;

   class interp_scoreboard;
      logic [EDGE_TYPE_WIDTH-1:0] edge_sel;
      interp_result_type expected_points[$];
      int mismatches;

      function new();
         edge_sel = EDGE_LINEAR;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      // floor(x / 2^n + 1/2)
      function wide_type round_half_up(wide_type x, int n);
         return (x + (wide_type'(1) <<< (n - 1))) >>> n;
      endfunction

      function void note_point(logic [POSITION_WIDTH-1:0] pos,
                               logic signed [VW-1:0] end_a, end_b, inner_one, inner_two);
         wide_type node_val[4];
         wide_type wt[4];
         wide_type sum, top, bottom;
         longint s, p;
         int count;
         interp_result_type res;
         s = UNIT_POS;
         p = pos;
         if (p > s)
            p = s;
         node_val[0] = end_a;
         node_val[1] = end_b;
         node_val[2] = inner_one;
         node_val[3] = inner_two;
         count = 0;
         case (edge_sel)
            EDGE_LINEAR: begin
               wt[0] = s - p;
               wt[1] = p;
               count = 2;
            end
            EDGE_QUADRATIC: begin
               wt[0] = round_half_up(wide_type'(s - p) * (s - 2 * p), FRAC);
               wt[1] = round_half_up(wide_type'(p) * (2 * p - s), FRAC);
               wt[2] = round_half_up(wide_type'(4 * p) * (s - p), FRAC);
               count = 3;
            end
            EDGE_CUBIC: begin
               wt[0] = round_half_up(wide_type'(s - p) * (3 * p - s) * (3 * p - 2 * s),
                                     2 * FRAC + 1);
               wt[1] = round_half_up(wide_type'(p) * (3 * p - s) * (3 * p - 2 * s),
                                     2 * FRAC + 1);
               wt[2] = round_half_up(wide_type'(9 * p) * (p - s) * (3 * p - 2 * s),
                                     2 * FRAC + 1);
               wt[3] = round_half_up(wide_type'(9 * p) * (s - p) * (3 * p - s),
                                     2 * FRAC + 1);
               count = 4;
            end
            default: count = 0;
         endcase
         sum = 0;
         for (int i = 0; i < count; i++)
            sum = sum + node_val[i] * wt[i];
         sum = round_half_up(sum, FRAC);
         top = VMAX;
         bottom = VMIN;
         res.clipped = 1'b1;
         if (sum > top)
            res.value = VMAX;
         else if (sum < bottom)
            res.value = VMIN;
         else begin
            res.value = sum[VW-1:0];
            res.clipped = 1'b0;
         end
         expected_points.push_back(res);
      endfunction

      function void check_result(logic signed [VW-1:0] value, logic clipped);
         interp_result_type want;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h flag %b", value, clipped);
         end else begin
            want = expected_points.pop_front();
            if (want.value !== value || want.clipped !== clipped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h flag %b, got %h flag %b",
                           want.value, want.clipped, value, clipped);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [POSITION_WIDTH-1:0] req_position;
   logic signed [VW-1:0] req_value_end_a;
   logic signed [VW-1:0] req_value_end_b;
   logic signed [VW-1:0] req_value_inner_one;
   logic signed [VW-1:0] req_value_inner_two;
   logic rsp_strobe;
   logic signed [VW-1:0] rsp_interpolated;
   logic rsp_saturated_flag;
   logic csr_write_en;
   logic [EDGE_TYPE_WIDTH-1:0] csr_write_data;

   interp_scoreboard board;
   int idle_cycles;

   edge_shape_interpolation_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_position       (req_position),
      .req_value_end_a    (req_value_end_a),
      .req_value_end_b    (req_value_end_b),
      .req_value_inner_one(req_value_inner_one),
      .req_value_inner_two(req_value_inner_two),
      .rsp_strobe         (rsp_strobe),
      .rsp_interpolated   (rsp_interpolated),
      .rsp_saturated_flag (rsp_saturated_flag),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && start && !busy)
         board.note_point(req_position, req_value_end_a, req_value_end_b,
                          req_value_inner_one, req_value_inner_two);
      if (!reset && rsp_strobe === 1'b1)
         board.check_result(rsp_interpolated, rsp_saturated_flag);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_point(logic [POSITION_WIDTH-1:0] pos,
                             logic signed [VW-1:0] end_a, end_b, inner_one, inner_two);
      req_position <= pos;
      req_value_end_a <= end_a;
      req_value_end_b <= end_b;
      req_value_inner_one <= inner_one;
      req_value_inner_two <= inner_two;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic drain_points();
      start <= 1'b0;
      // let the last beat's expectation land before looking at the queue
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_edge_type(logic [EDGE_TYPE_WIDTH-1:0] kind);
      drain_points();
      csr_write_en <= 1'b1;
      csr_write_data <= kind;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.edge_sel = kind;
   endtask

   function automatic logic signed [VW-1:0] random_node_value();
      case ($urandom_range(0, 6))
         0, 1: return $urandom;
         2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         3: return VMAX - $urandom_range(0, 255);
         4: return VMIN + $urandom_range(0, 255);
         5: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
         default: return $urandom_range(0, 32'h00FF_FFFF);
      endcase
   endfunction

   function automatic logic [POSITION_WIDTH-1:0] random_position();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return POSITION_WIDTH'(UNIT_POS / 3);
               2: return POSITION_WIDTH'(UNIT_POS / 2);
               3: return POSITION_WIDTH'((2 * UNIT_POS) / 3);
               default: return POSITION_WIDTH'(UNIT_POS);
            endcase
         end
         // beyond one: clamped by the block
         1: return POSITION_WIDTH'($urandom_range(UNIT_POS + 1, (1 << POSITION_WIDTH) - 1));
         default: return POSITION_WIDTH'($urandom_range(0, UNIT_POS));
      endcase
   endfunction

   task automatic run_random_phase(int count);
      int burst;
      int gap;
      burst = $urandom_range(1, 40);
      for (int n = 0; n < count; n++) begin
         send_point(random_position(), random_node_value(), random_node_value(),
                    random_node_value(), random_node_value());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            // roughly one burst in four runs straight on
            if ($urandom_range(0, 3) != 0) begin
               gap = $urandom_range(1, 12);
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      logic [EDGE_TYPE_WIDTH-1:0] all_kinds[4];
      logic [EDGE_TYPE_WIDTH-1:0] phase_kinds[8];
      all_kinds = '{EDGE_LINEAR, EDGE_QUADRATIC, EDGE_CUBIC, EDGE_UNUSED};
      phase_kinds = '{EDGE_CUBIC, EDGE_LINEAR, EDGE_UNUSED, EDGE_QUADRATIC,
                      EDGE_CUBIC, EDGE_QUADRATIC, EDGE_LINEAR, EDGE_CUBIC};
      board = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_position <= '0;
      req_value_end_a <= '0;
      req_value_end_b <= '0;
      req_value_inner_one <= '0;
      req_value_inner_two <= '0;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 4; k++) begin
         write_edge_type(all_kinds[k]);
         send_point('0, VMAX, VMIN, VMIN, VMAX);
         send_point(POSITION_WIDTH'(UNIT_POS), VMIN, VMAX, VMAX, VMIN);
         send_point(POSITION_WIDTH'(UNIT_POS / 2), VMAX, VMIN, VMAX, VMIN);
         // quarter point: on quadratic and cubic edges the inner weights push past the range both ways
         send_point(POSITION_WIDTH'(UNIT_POS / 4), VMAX, VMIN, VMAX, VMIN);
         send_point(POSITION_WIDTH'(UNIT_POS / 4), VMIN, VMAX, VMIN, VMAX);
         send_point({POSITION_WIDTH{1'b1}}, 32'sh0001_8000, -32'sh0001_8000,
                    32'sh0000_4000, -32'sh0000_4000);
      end

      foreach (phase_kinds[i]) begin
         write_edge_type(phase_kinds[i]);
         run_random_phase(PHASE_POINTS);
      end

      drain_points();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
design/esi_pkg.sv
design/esi_weight.sv
design/esi_mac.sv
design/edge_shape_interpolation_unit.sv
tb/testbench.sv
